>>> hdl/mfrd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the monochrome framebuffer rectangle drawer.
package mfrd_pkg;

  localparam int SCREEN_WIDTH  = 200;
  localparam int SCREEN_HEIGHT = 200;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int FRAME_BYTES   = ROW_BYTES * SCREEN_HEIGHT;

  localparam int ADDR_W  = $clog2(FRAME_BYTES);
  localparam int XW      = $clog2(SCREEN_WIDTH + 1);
  localparam int YW      = $clog2(SCREEN_HEIGHT + 1);
  localparam int BXW     = XW - 3;
  localparam int CW      = 18;
  localparam int COORD_W = 16;
  localparam int BADDR_W = 13;
  localparam int OP_W    = 3;

  localparam logic signed [CW-1:0] SCR_W_S = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] SCR_H_S = CW'(SCREEN_HEIGHT);

  localparam logic [7:0] FULL_BYTE  = 8'hFF;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_FILL    = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_OUTLINE = 3'd2,
    OP_RECT    = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_SEG,
    S_ROW0,
    S_RD,
    S_WR,
    S_RDB,
    S_RDW,
    S_DONE
  } state_t;

endpackage

>>> hdl/mfrd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mfrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mono_framebuffer_rect_drawer_unit.sv
`timescale 1ns / 1ps
// Monochrome 1bpp framebuffer with fill, pixel, rectangle and byte read-back.
//
// Usage: one command item enters on in_* (valid/stall); exactly one result item
// (out_read_data, the byte for a read, zero otherwise) leaves on out_* per item.
// in_stall is high while an item is being worked on; one item at a time.
// Work done per item:
//   fill all       : writes every byte (one byte write per cycle)
//   set pixel      : read-modify-write of one byte, none when off screen
//   filled rect    : read-modify-write of each byte of each clipped row, none if clipped away
//   outline        : each side in turn as a one-pixel-wide span, sides clipped away skipped
//   read byte      : one RAM read, zero result when the address is beyond the buffer
//   empty rectangle or unused code : no framebuffer access, zero result
// Every byte touched by a drawing op is a read-modify-write through the single
// framebuffer RAM: it is read in S_RD and written back in S_WR.
// Reset clears the sequencer and the result valid flag; the framebuffer contents
// are undefined until a fill or pixel writes cover them.
// A stalled result stays in the output register; the next item may be accepted
// and worked on meanwhile, and its result waits until the register frees.
module mono_framebuffer_rect_drawer_unit
  import mfrd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [COORD_W-1:0] in_x_pos,
  input  logic signed [COORD_W-1:0] in_y_pos,
  input  logic signed [COORD_W-1:0] in_rect_width,
  input  logic signed [COORD_W-1:0] in_rect_height,
  input  logic                      in_pixel_color,
  input  logic [BADDR_W-1:0]        in_byte_address,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_read_data
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [7:0] out_read_data_r;

  logic [OP_W-1:0]     op_r;
  logic signed [CW-1:0] x_r, y_r, w_r, h_r;
  logic                color_r;
  logic [BADDR_W-1:0]  baddr_r;

  logic [1:0]        seg_r, seg_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [BXW-1:0]    bx0_r, bx0_nxt, bxl_r, bxl_nxt, bx_r, bx_nxt;
  logic [2:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [YW-1:0]     row_r, row_nxt, y1_r, y1_nxt;
  logic [ADDR_W-1:0] rowbase_r, rowbase_nxt;
  logic [7:0]        res_r, res_nxt;

  logic in_accept, out_free, seg_last, seg_live;
  logic signed [CW-1:0] sx, sy, sw, sh, ex, ey, x0c, x1c, y0c, y1c, xl;
  logic [2:0] mask_lo, mask_hi;
  logic [7:0] pix_mask;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_read_data = out_read_data_r;

  // current segment: pixel, whole rect, or one side of an outline
  always_comb begin
    sx = x_r;
    sy = y_r;
    sw = w_r;
    sh = h_r;
    if (op_r == OP_PIXEL) begin
      sw = CW'(1);
      sh = CW'(1);
    end else if (op_r == OP_OUTLINE) begin
      case (seg_r)
        2'd0: sh = CW'(1);
        2'd1: begin
          sy = y_r + h_r - CW'(1);
          sh = CW'(1);
        end
        2'd2: sw = CW'(1);
        default: begin
          sx = x_r + w_r - CW'(1);
          sw = CW'(1);
        end
      endcase
    end
    ex  = sx + sw;
    ey  = sy + sh;
    x0c = (sx < 0) ? '0 : sx;
    y0c = (sy < 0) ? '0 : sy;
    x1c = (ex > SCR_W_S) ? SCR_W_S : ex;
    y1c = (ey > SCR_H_S) ? SCR_H_S : ey;
    xl  = x1c - CW'(1);
    seg_live = (sw > 0) && (sh > 0) && (x0c < x1c) && (y0c < y1c);
    seg_last = (op_r != OP_OUTLINE) || (seg_r == 2'd3);
  end

  always_comb begin
    mask_lo  = (bx_r == bx0_r) ? lo_r : 3'd0;
    mask_hi  = (bx_r == bxl_r) ? hi_r : 3'd7;
    pix_mask = (FULL_BYTE >> mask_lo) & (FULL_BYTE << (3'd7 - mask_hi));
  end

  always_comb begin
    state_nxt   = state_r;
    seg_nxt     = seg_r;
    cnt_nxt     = cnt_r;
    bx0_nxt     = bx0_r;
    bxl_nxt     = bxl_r;
    bx_nxt      = bx_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    row_nxt     = row_r;
    y1_nxt      = y1_r;
    rowbase_nxt = rowbase_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = rowbase_r + ADDR_W'(bx_r);
    ram_raddr   = rowbase_r + ADDR_W'(bx_r);
    ram_wdata   = color_r ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = EMPTY_BYTE;
          seg_nxt = 2'd0;
          cnt_nxt = '0;
          unique case (op_t'(in_operation)) inside
            OP_FILL:  state_nxt = S_FILL;
            OP_PIXEL: state_nxt = S_SEG;
            OP_OUTLINE, OP_RECT: begin
              if (in_rect_width > 0 && in_rect_height > 0) begin
                state_nxt = S_SEG;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_READ: begin
              if (32'(in_byte_address) < FRAME_BYTES) begin
                state_nxt = S_RDB;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = color_r ? FULL_BYTE : EMPTY_BYTE;
        if (32'(cnt_r) == FRAME_BYTES - 1) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_SEG: begin
        if (seg_live) begin
          bx0_nxt   = x0c[XW-1:3];
          lo_nxt    = x0c[2:0];
          bxl_nxt   = xl[XW-1:3];
          hi_nxt    = xl[2:0];
          row_nxt   = y0c[YW-1:0];
          y1_nxt    = y1c[YW-1:0];
          state_nxt = S_ROW0;
        end else if (seg_last) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt = seg_r + 2'd1;
        end
      end
      S_ROW0: begin
        rowbase_nxt = ADDR_W'(row_r * ROW_BYTES);
        bx_nxt      = bx0_r;
        state_nxt   = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        if (bx_r != bxl_r) begin
          bx_nxt    = bx_r + BXW'(1);
          state_nxt = S_RD;
        end else if (row_r + YW'(1) != y1_r) begin
          row_nxt     = row_r + YW'(1);
          rowbase_nxt = rowbase_r + ADDR_W'(ROW_BYTES);
          bx_nxt      = bx0_r;
          state_nxt   = S_RD;
        end else if (seg_last) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = S_SEG;
        end
      end
      S_RDB: begin
        ram_raddr = ADDR_W'(baddr_r);
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || (state_r == S_DONE && out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_operation;
      x_r     <= CW'(in_x_pos);
      y_r     <= CW'(in_y_pos);
      w_r     <= CW'(in_rect_width);
      h_r     <= CW'(in_rect_height);
      color_r <= in_pixel_color;
      baddr_r <= in_byte_address;
    end
    if (state_r == S_DONE && out_free) begin
      out_read_data_r <= res_r;
    end
    seg_r     <= seg_nxt;
    cnt_r     <= cnt_nxt;
    bx0_r     <= bx0_nxt;
    bxl_r     <= bxl_nxt;
    bx_r      <= bx_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    row_r     <= row_nxt;
    y1_r      <= y1_nxt;
    rowbase_r <= rowbase_nxt;
    res_r     <= res_nxt;
  end

  mfrd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> 32'(ram_waddr) < FRAME_BYTES)
    else $error("framebuffer write beyond buffer");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> (row_r < y1_r) && (bx_r <= bxl_r))
    else $error("span walk outside clipped bounds");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");
`endif

endmodule
